>>> hw/rtl/kms_pkg.sv
// ----------------------------------------------------------------------------
// kms_pkg
// Shared types, codes and key table for the 4x4 keypad matrix scanner.
// ----------------------------------------------------------------------------
package kms_pkg;

	// request codes carried by the action field
	typedef enum logic {
		ACT_SCAN = 1'b0,
		ACT_READ = 1'b1
	} action_t;

	// scan phase codes; values above PHASE_COL4 are unreachable
	localparam logic [2:0] PHASE_INIT = 3'd0;
	localparam logic [2:0] PHASE_COL1 = 3'd1;
	localparam logic [2:0] PHASE_COL4 = 3'd4;

	// row sample patterns, active low
	localparam logic [3:0] ROWS_IDLE = 4'hF;
	localparam logic [3:0] ROW1_LOW  = 4'hE;
	localparam logic [3:0] ROW2_LOW  = 4'hD;
	localparam logic [3:0] ROW3_LOW  = 4'hB;
	localparam logic [3:0] ROW4_LOW  = 4'h7;

	// scanner state
	typedef struct packed {
		logic [2:0] scan_phase;
		logic [3:0] current_key;
		logic       key_seen;
		logic       pending_flag;
		logic [2:0] last_press_column;
		logic       released_flag;
	} kms_state_t;

	// one result beat
	typedef struct packed {
		logic [2:0] drive_column;
		logic [3:0] key_code;
		logic       key_valid;
		logic       press_pending;
	} kms_result_t;

	// hex key under a column (0..3) and row (0..3)
	function automatic logic [3:0] key_lookup(input logic [1:0] col, input logic [1:0] row);
		logic [3:0] key;
		unique case ({col, row})
			4'h0: key = 4'h1;
			4'h1: key = 4'h4;
			4'h2: key = 4'h7;
			4'h3: key = 4'h0;
			4'h4: key = 4'h2;
			4'h5: key = 4'h5;
			4'h6: key = 4'h8;
			4'h7: key = 4'hF;
			4'h8: key = 4'h3;
			4'h9: key = 4'h6;
			4'hA: key = 4'h9;
			4'hB: key = 4'hE;
			4'hC: key = 4'hA;
			4'hD: key = 4'hB;
			4'hE: key = 4'hC;
			default: key = 4'hD;
		endcase
		return key;
	endfunction

endpackage

>>> hw/rtl/kms_step.sv
// ----------------------------------------------------------------------------
// kms_step
// Next-state and result logic of the scanner for one request.
// ----------------------------------------------------------------------------
module kms_step (
	input  kms_pkg::kms_state_t  state,
	input  kms_pkg::action_t     action,
	input  logic [3:0]           row_sample,
	output kms_pkg::kms_state_t  state_next,
	output kms_pkg::kms_result_t result
);
	import kms_pkg::*;

	logic       row_hit;
	logic [1:0] row_idx;
	logic       phase_active;
	logic [2:0] phase_next;
	logic [2:0] tag;
	logic [1:0] col_idx;

	// single low row decode
	always_comb begin
		row_hit = 1'b1;
		row_idx = 2'd0;
		unique case (row_sample)
			ROW1_LOW: row_idx = 2'd0;
			ROW2_LOW: row_idx = 2'd1;
			ROW3_LOW: row_idx = 2'd2;
			ROW4_LOW: row_idx = 2'd3;
			default:  row_hit = 1'b0;
		endcase
	end

	// phase advance and column tag
	assign phase_active = (state.scan_phase >= PHASE_COL1) && (state.scan_phase <= PHASE_COL4);
	assign col_idx      = 2'(state.scan_phase - PHASE_COL1);
	assign phase_next   = (!phase_active || state.scan_phase == PHASE_COL4) ? PHASE_COL1
	                    : 3'(state.scan_phase + 3'd1);
	assign tag          = 3'(phase_next - 3'd1);

	// state update and result
	always_comb begin
		state_next = state;
		result.press_pending = state.pending_flag;
		unique case (action)
			ACT_READ: begin
				state_next.pending_flag = 1'b0;
			end
			default: begin
				if (phase_active && row_hit) begin
					state_next.current_key = key_lookup(col_idx, row_idx);
					state_next.key_seen    = 1'b1;
				end
				if (row_sample == ROWS_IDLE && tag == state.last_press_column) begin
					state_next.released_flag = 1'b1;
				end else if (row_sample != ROWS_IDLE && state.released_flag) begin
					state_next.pending_flag      = 1'b1;
					state_next.last_press_column = tag;
					state_next.released_flag     = 1'b0;
				end
				state_next.scan_phase = phase_next;
				result.press_pending  = state_next.pending_flag;
			end
		endcase
		result.drive_column = state_next.scan_phase;
		result.key_code     = state_next.current_key;
		result.key_valid    = state_next.key_seen;
	end

endmodule

>>> hw/rtl/keypad_matrix_scanner.sv
// ----------------------------------------------------------------------------
// keypad_matrix_scanner
// 4x4 key matrix scanner with column drive, key decode and press tracking.
// ----------------------------------------------------------------------------
// Each input beat is either a scan tick carrying the active-low row sample
// taken under the column driven so far, or a read request. Every beat gives
// one result beat: the column to drive next, the latest key, whether any key
// has been seen, and the press-pending flag (before clearing, on a read).
// The block takes one beat per cycle while the output is not stalled; the
// beat is held in the input register, and the scanner state is updated as
// it moves into the result register, from which its result is offered. A
// stalled output holds both registers full.
// ----------------------------------------------------------------------------
module keypad_matrix_scanner (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       action,
	input  logic [3:0] row_sample,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] drive_column,
	output logic [3:0] key_code,
	output logic       key_valid,
	output logic       press_pending
);
	import kms_pkg::*;

	logic        valid_s1;
	action_t     action_s1;
	logic [3:0]  sample_s1;
	logic        valid_s2;
	kms_result_t result_s2;
	kms_state_t  state_q;
	kms_state_t  state_next;
	kms_result_t result;
	logic        advance;

	// handshake
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			action_s1 <= action_t'(action);
			sample_s1 <= row_sample;
		end
	end

	// decode and update
	kms_step u_step (
		.state      (state_q),
		.action     (action_s1),
		.row_sample (sample_s1),
		.state_next (state_next),
		.result     (result)
	);

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid     = valid_s2;
	assign drive_column  = result_s2.drive_column;
	assign key_code      = result_s2.key_code;
	assign key_valid     = result_s2.key_valid;
	assign press_pending = result_s2.press_pending;

endmodule

>>> hw/rtl/kms_checker.sv
// ----------------------------------------------------------------------------
// kms_checker
// Port-level checks of the keypad scanner, bound to the top level.
// ----------------------------------------------------------------------------
module kms_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] drive_column,
	input logic [3:0] key_code,
	input logic       key_valid
);
	logic seen_q;

	// key seen on any delivered beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (out_valid && out_ready && key_valid) begin
			seen_q <= 1'b1;
		end
	end

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drive_column) && $stable(key_code))
		else $error("result changed while stalled");

	// driven column is none or one of the four, a read before the first tick shows none
	a_column_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> drive_column <= 3'd4)
		else $error("driven column out of range");

	// key valid never drops once shown
	a_seen_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seen_q |-> key_valid)
		else $error("key valid dropped");

	// no key decoded yet means key code zero
	a_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !key_valid |-> key_code == 4'd0)
		else $error("key code set before any decode");

endmodule

bind keypad_matrix_scanner kms_checker u_kms_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.drive_column (drive_column),
	.key_code     (key_code),
	.key_valid    (key_valid)
);

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 4x4 keypad matrix scanner.
// ----------------------------------------------------------------------------
// A short table of directed beats covers the init tick, every column and row,
// multi-row and empty samples, release and press tracking and reads. Random
// scan and read beats follow under three idling profiles. Every accepted beat
// is run through a local model of the scanner, and each result beat is
// compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import kms_pkg::*;

	localparam int RESET_CYCLES  = 12;
	localparam int STALL_LIMIT   = 1000;
	localparam int RANDOM_BEATS  = 650;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_REPORTS   = 10;

	// one directed beat, with its result typed in where it is obvious
	typedef struct {
		action_t     act;
		logic [3:0]  rows;
		bit          typed;
		kms_result_t want;
	} stim_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       action = ACT_SCAN;
	logic [3:0] row_sample = ROWS_IDLE;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [2:0] drive_column;
	logic [3:0] key_code;
	logic       key_valid;
	logic       press_pending;

	// scanner model state
	logic [2:0] col_phase;
	logic [3:0] latest_key;
	logic       key_decoded;
	logic       press_flag;
	logic [2:0] press_tag;
	logic       release_seen;

	kms_result_t results_due[$];
	int          fault_count = 0;
	int          send_idle_pct = 9;
	int          recv_idle_pct = 61;
	int          quiet_cycles = 0;

	// hex key per column (outer) and row (inner)
	logic [3:0] key_map [4][4] = '{
		'{4'h1, 4'h4, 4'h7, 4'h0},
		'{4'h2, 4'h5, 4'h8, 4'hF},
		'{4'h3, 4'h6, 4'h9, 4'hE},
		'{4'hA, 4'hB, 4'hC, 4'hD}
	};

	stim_row_t directed_rows [24] = '{
		'{ACT_READ, 4'hF, 1'b1, {3'd0, 4'h0, 1'b0, 1'b0}},
		'{ACT_SCAN, 4'hF, 1'b1, {3'd1, 4'h0, 1'b0, 1'b0}},
		'{ACT_SCAN, 4'hE, 1'b1, {3'd2, 4'h1, 1'b1, 1'b1}},
		'{ACT_READ, 4'h0, 1'b1, {3'd2, 4'h1, 1'b1, 1'b1}},
		'{ACT_READ, 4'hF, 1'b1, {3'd2, 4'h1, 1'b1, 1'b0}},
		'{ACT_SCAN, 4'hD, 1'b0, '0},
		'{ACT_SCAN, 4'hB, 1'b0, '0},
		'{ACT_SCAN, 4'h7, 1'b0, '0},
		'{ACT_SCAN, 4'h7, 1'b0, '0},
		'{ACT_SCAN, 4'h7, 1'b0, '0},
		'{ACT_SCAN, 4'h0, 1'b0, '0},
		'{ACT_SCAN, 4'hC, 1'b0, '0},
		'{ACT_SCAN, 4'hF, 1'b0, '0},
		'{ACT_SCAN, 4'h3, 1'b0, '0},
		'{ACT_SCAN, 4'hF, 1'b0, '0},
		'{ACT_SCAN, 4'hF, 1'b0, '0},
		'{ACT_SCAN, 4'hF, 1'b0, '0},
		'{ACT_SCAN, 4'hF, 1'b0, '0},
		'{ACT_SCAN, 4'hE, 1'b0, '0},
		'{ACT_READ, 4'h5, 1'b0, '0},
		'{ACT_SCAN, 4'hE, 1'b0, '0},
		'{ACT_SCAN, 4'hD, 1'b0, '0},
		'{ACT_SCAN, 4'h8, 1'b0, '0},
		'{ACT_SCAN, 4'hB, 1'b0, '0}
	};

	keypad_matrix_scanner uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.row_sample   (row_sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.drive_column (drive_column),
		.key_code     (key_code),
		.key_valid    (key_valid),
		.press_pending(press_pending)
	);

	// 8 ns clock
	initial begin
		forever #4 clk = ~clk;
	end

	// advance the scanner model by one beat and return its result
	function automatic kms_result_t next_scan_result(input action_t act,
			input logic [3:0] rows);
		kms_result_t res;
		logic [2:0]  nxt;
		logic [2:0]  tag;
		logic        pend_out;
		int          row_idx;
		if (act == ACT_READ) begin
			pend_out   = press_flag;
			press_flag = 1'b0;
		end else begin
			if (col_phase >= PHASE_COL1 && col_phase <= PHASE_COL4) begin
				// decode only when exactly one row is low
				case (rows)
					ROW1_LOW: row_idx = 0;
					ROW2_LOW: row_idx = 1;
					ROW3_LOW: row_idx = 2;
					ROW4_LOW: row_idx = 3;
					default:  row_idx = -1;
				endcase
				if (row_idx >= 0) begin
					latest_key  = key_map[col_phase - 3'd1][row_idx];
					key_decoded = 1'b1;
				end
				nxt = (col_phase == PHASE_COL4) ? PHASE_COL1 : col_phase + 3'd1;
			end else begin
				nxt = PHASE_COL1;
			end
			// release and press tracking, tag wraps column 4 onto 0
			tag = nxt - 3'd1;
			if (rows == ROWS_IDLE && tag == press_tag) begin
				release_seen = 1'b1;
			end else if (rows != ROWS_IDLE && release_seen) begin
				press_flag   = 1'b1;
				press_tag    = tag;
				release_seen = 1'b0;
			end
			col_phase = nxt;
			pend_out  = press_flag;
		end
		res.drive_column  = col_phase;
		res.key_code      = latest_key;
		res.key_valid     = key_decoded;
		res.press_pending = pend_out;
		return res;
	endfunction

	// offer one input beat, wait for it to be taken, then log its result
	task automatic send_beat(input action_t act, input logic [3:0] rows,
			input bit typed, input kms_result_t want);
		kms_result_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		action     <= act;
		row_sample <= rows;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		res = next_scan_result(act, rows);
		results_due.push_back(typed ? want : res);
	endtask

	// random beats: mostly well-formed press and release samples, some noise
	task automatic send_random(input int count);
		logic [3:0] rows;
		int         pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				rows = ROWS_IDLE;
			end else if (pick < 85) begin
				case ($urandom_range(3))
					0:       rows = ROW1_LOW;
					1:       rows = ROW2_LOW;
					2:       rows = ROW3_LOW;
					default: rows = ROW4_LOW;
				endcase
			end else begin
				rows = 4'($urandom_range(15));
			end
			if ($urandom_range(99) < 15) begin
				send_beat(ACT_READ, 4'($urandom_range(15)), 1'b0, '0);
			end else begin
				send_beat(ACT_SCAN, rows, 1'b0, '0);
			end
		end
	endtask

	// result side: compare against the oldest expectation, then pick next ready
	always @(posedge clk) begin
		kms_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				if (fault_count < MAX_REPORTS) begin
					$display("unexpected result beat: col %0d key %h valid %b pend %b",
						drive_column, key_code, key_valid, press_pending);
				end
				fault_count++;
			end else begin
				want = results_due.pop_front();
				if (drive_column !== want.drive_column || key_code !== want.key_code ||
						key_valid !== want.key_valid ||
						press_pending !== want.press_pending) begin
					if (fault_count < MAX_REPORTS) begin
						$display("mismatch: col %0d/%0d key %h/%h valid %b/%b pend %b/%b",
							want.drive_column, drive_column, want.key_code, key_code,
							want.key_valid, key_valid, want.press_pending, press_pending);
					end
					fault_count++;
				end
			end
		end
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles + 1 >= STALL_LIMIT) begin
				$display("testbench: FAIL");
				$finish;
			end
		end
	end

	// main sequence
	initial begin
		col_phase    = PHASE_INIT;
		latest_key   = 4'h0;
		key_decoded  = 1'b0;
		press_flag   = 1'b0;
		press_tag    = 3'd0;
		release_seen = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (directed_rows[i]) begin
			send_beat(directed_rows[i].act, directed_rows[i].rows,
				directed_rows[i].typed, directed_rows[i].want);
		end

		// random beats under three idling profiles
		send_random(RANDOM_BEATS);
		send_idle_pct = 61;
		recv_idle_pct = 9;
		send_random(RANDOM_BEATS);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random(RANDOM_BEATS);
		in_valid <= 1'b0;

		// drain and let the pipeline settle
		while (results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (fault_count == 0 && results_due.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/kms_pkg.sv
hw/rtl/kms_step.sv
hw/rtl/keypad_matrix_scanner.sv
hw/rtl/kms_checker.sv
verif/testbench.sv
